[design/ppw_pkg.sv]
`default_nettype none

package ppw_pkg;

    localparam int COORD_W   = 32;
    localparam int VP_POS_W  = 16;
    localparam int VP_SIZE_W = 14;
    localparam int COEF_AW   = 5;
    localparam int COEF_N    = 32;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int VIEW_W    = MUL_W + VP_SIZE_W + 3;

    localparam logic [VP_SIZE_W-1:0] RESET_WIDTH  = 14'd640;
    localparam logic [VP_SIZE_W-1:0] RESET_HEIGHT = 14'd480;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_PROJECT = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        CFG_LEFT   = 2'd0,
        CFG_BOTTOM = 2'd1,
        CFG_WIDTH  = 2'd2,
        CFG_HEIGHT = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_WCHK,
        S_DIV_INIT,
        S_DIV_STEP,
        S_DIV_END,
        S_VIEW_X,
        S_VIEW_Y,
        S_VIEW_Z,
        S_FINISH
    } state_t;

endpackage

`default_nettype wire

[design/point_project_to_window_unit.sv]
`default_nettype none
// Channel   Handshake                  Payload
// item      item_valid / item_ready    op, coef_index, coef_value, point_x, point_y, point_z
// result    result_valid / result_ready win_x, win_y, win_z, success
// cfg       cfg_valid / cfg_ready      cfg_index, cfg_data
//
// A load transfer leaves the block ready and gives no result. A project transfer runs two
// passes of 16 multiply-accumulates on the one 33x33 multiplier, each with a drain, a check
// of clip w, three restoring divisions by clip w, viewport mapping in S_VIEW_X, S_VIEW_Y and
// S_VIEW_Z and a load of the output register, then offers its result. A zero clip w skips
// the divisions and the mapping. rst_n clears the control state and sets the viewport
// registers to left 0, bottom 0, width 640, height 480; the coefficient memory has no reset
// value. A finished result waits in the output register while the next item is taken.

module point_project_to_window_unit
    import ppw_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        item_valid,
    output logic                       item_ready,
    input  wire                        op,
    input  wire  [COEF_AW-1:0]         coef_index,
    input  wire  signed [COORD_W-1:0]  coef_value,
    input  wire  signed [COORD_W-1:0]  point_x,
    input  wire  signed [COORD_W-1:0]  point_y,
    input  wire  signed [COORD_W-1:0]  point_z,
    output logic                       result_valid,
    input  wire                        result_ready,
    output logic signed [COORD_W-1:0]  win_x,
    output logic signed [COORD_W-1:0]  win_y,
    output logic signed [COORD_W-1:0]  win_z,
    output logic                       success,
    input  wire                        cfg_valid,
    output logic                       cfg_ready,
    input  wire  [1:0]                 cfg_index,
    input  wire  [VP_POS_W-1:0]        cfg_data
);

    localparam int ACC_W = PROD_W - FRAC_BITS;
    localparam int NUM_W = COORD_W + FRAC_BITS;
    localparam int REM_W = COORD_W + 1;

    localparam coord_t ONE   = {{(COORD_W-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam coord_t C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    function automatic coord_t sat_acc(input logic signed [ACC_W-1:0] v);
        coord_t r;
        if (v[ACC_W-1:COORD_W-1] == '0 || v[ACC_W-1:COORD_W-1] == '1)
            r = v[COORD_W-1:0];
        else
            r = v[ACC_W-1] ? C_MIN : C_MAX;
        return r;
    endfunction

    function automatic coord_t sat_view(input logic signed [VIEW_W-1:0] v);
        coord_t r;
        if (v[VIEW_W-1:COORD_W-1] == '0 || v[VIEW_W-1:COORD_W-1] == '1)
            r = v[COORD_W-1:0];
        else
            r = v[VIEW_W-1] ? C_MIN : C_MAX;
        return r;
    endfunction

    state_t state_reg, state_next;
    logic [COEF_AW-1:0] k_reg, k_next;
    logic [COEF_AW-1:0] k1_reg, k2_reg;
    logic v1_reg, v2_reg;
    logic [4:0] cnt_reg, cnt_next;
    logic [1:0] d_reg, d_next;
    logic issue, out_load, item_fire;
    logic result_valid_reg, result_valid_next;

    logic signed [VP_POS_W-1:0] vp_left_reg, vp_bottom_reg;
    logic [VP_SIZE_W-1:0] vp_width_reg, vp_height_reg;

    coord_t coef_mem [COEF_N];
    logic [COEF_AW-1:0] rd_addr;
    coord_t rd_data_reg;

    coord_t pt_reg [4];
    coord_t eye_reg [4];
    coord_t clip_reg [4];
    coord_t ndc_reg [3];

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_shift;
    logic signed [ACC_W-1:0] acc_reg, acc_sum;
    coord_t acc_sat, mac_src;

    coord_t clip_sel, w_val;
    logic [COORD_W-1:0] num_abs, w_abs;
    logic [NUM_W-1:0] num_init;
    logic div_ovf;
    logic [REM_W-1:0] rem_reg, rem_next, trial;
    logic [COORD_W-1:0] num_reg, den_reg, quo_reg;
    logic ovf_reg, neg_reg, ge;
    coord_t q_sat;

    logic signed [VIEW_W-1:0] view_sum;
    logic signed [MUL_W-1:0] z_sum;
    coord_t view_sat;
    coord_t wx_reg, wy_reg, wz_reg;
    logic ok_reg;
    coord_t win_x_reg, win_y_reg, win_z_reg;
    logic success_reg;

    assign item_ready   = (state_reg == S_IDLE);
    assign item_fire    = item_valid && item_ready;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign win_x        = win_x_reg;
    assign win_y        = win_y_reg;
    assign win_z        = win_z_reg;
    assign success      = success_reg;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        d_next     = d_reg;
        issue      = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                k_next = '0;
                if (item_valid && op == OP_PROJECT)
                    state_next = S_MAC;
            end
            S_MAC:
            begin
                issue  = 1'b1;
                k_next = k_reg + 1'b1;
                if (k_reg[3:0] == 4'hF)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                    state_next = k_reg[4] ? S_MAC : S_WCHK;
            end
            S_WCHK:
            begin
                d_next     = '0;
                state_next = (clip_reg[3] == '0) ? S_FINISH : S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                cnt_next   = '0;
                state_next = S_DIV_STEP;
            end
            S_DIV_STEP:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                    state_next = S_DIV_END;
            end
            S_DIV_END:
            begin
                d_next     = d_reg + 1'b1;
                state_next = (d_reg == 2'd2) ? S_VIEW_X : S_DIV_INIT;
            end
            S_VIEW_X: state_next = S_VIEW_Y;
            S_VIEW_Y: state_next = S_VIEW_Z;
            S_VIEW_Z: state_next = S_FINISH;
            S_FINISH:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (out_load)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            k_reg            <= '0;
            k1_reg           <= '0;
            k2_reg           <= '0;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            cnt_reg          <= '0;
            d_reg            <= '0;
            result_valid_reg <= 1'b0;
            vp_left_reg      <= '0;
            vp_bottom_reg    <= '0;
            vp_width_reg     <= RESET_WIDTH;
            vp_height_reg    <= RESET_HEIGHT;
        end
        else
        begin
            state_reg        <= state_next;
            k_reg            <= k_next;
            k1_reg           <= k_reg;
            k2_reg           <= k1_reg;
            v1_reg           <= issue;
            v2_reg           <= v1_reg;
            cnt_reg          <= cnt_next;
            d_reg            <= d_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_LEFT:   vp_left_reg   <= cfg_data;
                    CFG_BOTTOM: vp_bottom_reg <= cfg_data;
                    CFG_WIDTH:  vp_width_reg  <= cfg_data[VP_SIZE_W-1:0];
                    CFG_HEIGHT: vp_height_reg <= cfg_data[VP_SIZE_W-1:0];
                    default:    vp_left_reg   <= vp_left_reg;
                endcase
            end
        end
    end

    // Coefficient (row, col) of a matrix sits at col*4+row; the sequence runs row-major.
    assign rd_addr = {k_reg[4], k_reg[1:0], k_reg[3:2]};

    always_ff @(posedge clk)
    begin
        if (item_fire && op == OP_LOAD)
            coef_mem[coef_index] <= coef_value;
        rd_data_reg <= coef_mem[rd_addr];
    end

    always_comb
    begin
        mac_src = k1_reg[4] ? eye_reg[k1_reg[1:0]] : pt_reg[k1_reg[1:0]];
        unique case (state_reg)
            S_VIEW_X:
            begin
                mul_a = {ONE[COORD_W-1], ONE} + {ndc_reg[0][COORD_W-1], ndc_reg[0]};
                mul_b = {{(MUL_W-VP_SIZE_W){1'b0}}, vp_width_reg};
            end
            S_VIEW_Y:
            begin
                mul_a = {ONE[COORD_W-1], ONE} + {ndc_reg[1][COORD_W-1], ndc_reg[1]};
                mul_b = {{(MUL_W-VP_SIZE_W){1'b0}}, vp_height_reg};
            end
            default:
            begin
                mul_a = {rd_data_reg[COORD_W-1], rd_data_reg};
                mul_b = {mac_src[COORD_W-1], mac_src};
            end
        endcase
    end

    assign prod_shift = prod_reg >>> FRAC_BITS;
    assign acc_sum    = ((k2_reg[1:0] == 2'd0) ? '0 : acc_reg) + prod_shift[ACC_W-1:0];
    assign acc_sat    = sat_acc(acc_sum);

    assign clip_sel = clip_reg[d_reg];
    assign w_val    = clip_reg[3];
    assign num_abs  = clip_sel[COORD_W-1] ? COORD_W'(-clip_sel) : COORD_W'(clip_sel);
    assign w_abs    = w_val[COORD_W-1] ? COORD_W'(-w_val) : COORD_W'(w_val);
    assign num_init = {num_abs, {FRAC_BITS{1'b0}}};
    assign div_ovf  = {{(COORD_W-FRAC_BITS){1'b0}}, num_init[NUM_W-1:COORD_W]} >= w_abs;

    assign trial    = {rem_reg[COORD_W-1:0], num_reg[COORD_W-1]};
    assign ge       = trial >= {1'b0, den_reg};
    assign rem_next = ge ? (trial - {1'b0, den_reg}) : trial;

    always_comb
    begin
        if (ovf_reg || (!neg_reg && quo_reg[COORD_W-1]) ||
            (neg_reg && quo_reg > C_MIN))
            q_sat = neg_reg ? C_MIN : C_MAX;
        else
            q_sat = neg_reg ? coord_t'(-quo_reg) : coord_t'(quo_reg);
    end

    assign view_sum = ((state_reg == S_VIEW_Y)
                          ? {{(VIEW_W-VP_POS_W){vp_left_reg[VP_POS_W-1]}}, vp_left_reg}
                          : {{(VIEW_W-VP_POS_W){vp_bottom_reg[VP_POS_W-1]}}, vp_bottom_reg})
                      * (VIEW_W'(1) << FRAC_BITS)
                      + prod_reg[VIEW_W:1];
    assign view_sat = sat_view(view_sum);
    assign z_sum    = {ONE[COORD_W-1], ONE} + {ndc_reg[2][COORD_W-1], ndc_reg[2]};

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (item_fire && op == OP_PROJECT)
        begin
            pt_reg[0] <= point_x;
            pt_reg[1] <= point_y;
            pt_reg[2] <= point_z;
            pt_reg[3] <= ONE;
        end
        if (v2_reg)
        begin
            acc_reg <= acc_sum;
            if (k2_reg[1:0] == 2'd3)
            begin
                if (k2_reg[4])
                    clip_reg[k2_reg[3:2]] <= acc_sat;
                else
                    eye_reg[k2_reg[3:2]] <= acc_sat;
            end
        end
        if (state_reg == S_DIV_INIT)
        begin
            rem_reg <= {{(REM_W-FRAC_BITS){1'b0}}, num_init[NUM_W-1:COORD_W]};
            num_reg <= num_init[COORD_W-1:0];
            den_reg <= w_abs;
            quo_reg <= '0;
            ovf_reg <= div_ovf;
            neg_reg <= clip_sel[COORD_W-1] ^ w_val[COORD_W-1];
        end
        if (state_reg == S_DIV_STEP)
        begin
            rem_reg <= rem_next;
            num_reg <= {num_reg[COORD_W-2:0], 1'b0};
            quo_reg <= {quo_reg[COORD_W-2:0], ge};
        end
        if (state_reg == S_DIV_END)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (d_reg == 2'(i))
                    ndc_reg[i] <= q_sat;
            end
        end
        if (state_reg == S_WCHK)
        begin
            wx_reg <= '0;
            wy_reg <= '0;
            wz_reg <= '0;
            ok_reg <= 1'b0;
        end
        if (state_reg == S_VIEW_Y)
            wx_reg <= view_sat;
        if (state_reg == S_VIEW_Z)
        begin
            wy_reg <= view_sat;
            wz_reg <= z_sum[MUL_W-1:1];
            ok_reg <= 1'b1;
        end
        if (out_load)
        begin
            win_x_reg   <= wx_reg;
            win_y_reg   <= wy_reg;
            win_z_reg   <= wz_reg;
            success_reg <= ok_reg;
        end
    end

endmodule

`default_nettype wire

[design/ppw_checker.sv]
`default_nettype none

module ppw_checker
    import ppw_pkg::*;
(
    input wire                clk,
    input wire                rst_n,
    input wire                item_valid,
    input wire                item_ready,
    input wire                op,
    input wire                result_valid,
    input wire                result_ready,
    input wire [COORD_W-1:0]  win_x,
    input wire [COORD_W-1:0]  win_y,
    input wire [COORD_W-1:0]  win_z,
    input wire                success
);

    // A result that waits keeps its payload until the transfer.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(win_x) && $stable(win_y) && $stable(win_z) &&
            $stable(success))
        else $error("result payload changed while stalled");

    // A projection keeps the block busy for the following cycle.
    a_project_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && op == OP_PROJECT |=> !item_ready)
        else $error("item taken right after a projection");

    // A coefficient load leaves the block ready for another item.
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && op == OP_LOAD |=> item_ready)
        else $error("block busy after a coefficient load");

    // A failed projection carries no coordinates.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !success |-> win_x == '0 && win_y == '0 && win_z == '0)
        else $error("failed projection with nonzero coordinates");

endmodule

bind point_project_to_window_unit ppw_checker u_ppw_checker (.*);

`default_nettype wire
